[rtl/wf23_pkg.sv]
// Shared types, constants and fixed-point helpers of the Winograd F(2,3) output block.
package wf23_pkg;

  // Number of channel lanes held in the stores.
  localparam int CHANNELS = 8;
  // Transformed rows per channel and taps per row.
  localparam int ROWS = 3;
  localparam int TAPS = 4;

  // Field widths fixed by the interface.
  localparam int Q_W    = 32;
  localparam int CH_W   = 3;
  localparam int ROW_W  = 2;
  localparam int MODE_W = 2;

  // Store geometry.
  localparam int WT_ROWS = CHANNELS * ROWS;
  localparam int PS_AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int WT_AW   = (WT_ROWS > 1) ? $clog2(WT_ROWS) : 1;

  // First row, which starts an accumulation, and last row, which closes it and emits a result.
  localparam logic [ROW_W-1:0] ROW_FIRST = ROW_W'(0);
  localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(ROWS - 1);

  localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLAMP_MIN = 1'b0,
    CFG_CLAMP_MAX = 1'b1
  } cfg_idx_e;

  // Item modes.
  typedef enum logic [MODE_W-1:0] {
    MODE_WEIGHT = 2'd0,
    MODE_BIAS   = 2'd1,
    MODE_DATA   = 2'd2
  } mode_e;

  // One row of four Q16.16 words, tap k in slot k.
  typedef logic [TAPS-1:0][Q_W-1:0] row_t;

  // Saturating signed add.
  function automatic logic signed [Q_W-1:0] sat_add(input logic signed [Q_W-1:0] a,
                                                    input logic signed [Q_W-1:0] b);
    logic signed [Q_W:0] s;
    s = $signed({a[Q_W-1], a}) + $signed({b[Q_W-1], b});
    if (s[Q_W] != s[Q_W-1]) begin
      return s[Q_W] ? Q_MIN : Q_MAX;
    end
    return $signed(s[Q_W-1:0]);
  endfunction

  // Saturating signed subtract.
  function automatic logic signed [Q_W-1:0] sat_sub(input logic signed [Q_W-1:0] a,
                                                    input logic signed [Q_W-1:0] b);
    logic signed [Q_W:0] s;
    s = $signed({a[Q_W-1], a}) - $signed({b[Q_W-1], b});
    if (s[Q_W] != s[Q_W-1]) begin
      return s[Q_W] ? Q_MIN : Q_MAX;
    end
    return $signed(s[Q_W-1:0]);
  endfunction

  // Drop the 16 fraction bits of a full product (floor) and saturate to 32 bits.
  function automatic logic signed [Q_W-1:0] prod_sat(input logic signed [2*Q_W-1:0] p);
    logic [2*Q_W-17:0] sh;
    sh = p[2*Q_W-1:16];
    if (sh[2*Q_W-17:Q_W-1] == {(Q_W-15){sh[Q_W-1]}}) begin
      return $signed(sh[Q_W-1:0]);
    end
    return sh[2*Q_W-17] ? Q_MIN : Q_MAX;
  endfunction

  // Clamp against the upper bound first, then the lower bound.
  function automatic logic signed [Q_W-1:0] clamp(input logic signed [Q_W-1:0] o,
                                                  input logic signed [Q_W-1:0] lo,
                                                  input logic signed [Q_W-1:0] hi);
    logic signed [Q_W-1:0] r;
    r = (o > hi) ? hi : o;
    r = (r < lo) ? lo : r;
    return r;
  endfunction

endpackage

[rtl/winograd_f23_depthwise_output.sv]
// Top level of the Winograd F(2,3) depthwise multiply and output transform.
//
// Input words arrive on a valid/ready channel: mode 0 loads one weight row of a
// channel, mode 1 loads the channel bias, mode 2 carries one transformed data
// row. Data rows 0, 1 and 2 of a channel build four partial sums; row 2 emits
// one result word with the even and odd output pixels after bias and clamp.
// Result words leave on a valid/ready channel. The user must set the clamp bounds
// by a plain write port only while the block is idle; the block does not enforce it.
// Weights, biases and partial sums sit in synchronous memories read when the
// word is accepted. A partial sum being written back is forwarded to a younger
// word of the same channel, so one word is accepted every cycle the pipeline runs.
// A row 2 word passes through a six-stage pipeline (memory read, multiply,
// accumulate and write back, three add stages) whose last add stage writes the
// output register.
// The pipeline stops only when a result waits in the output register and the
// receiver does not take it while the next result is due; words that give no
// result keep flowing. Reset empties the pipeline and sets the clamp bounds to
// the full signed range; the memories keep their contents until written.
module winograd_f23_depthwise_output (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [wf23_pkg::MODE_W-1:0]  mode_i,
  input  logic [wf23_pkg::CH_W-1:0]    channel_i,
  input  logic [wf23_pkg::ROW_W-1:0]   row_i,
  input  logic signed [wf23_pkg::Q_W-1:0] value_0_i,
  input  logic signed [wf23_pkg::Q_W-1:0] value_1_i,
  input  logic signed [wf23_pkg::Q_W-1:0] value_2_i,
  input  logic signed [wf23_pkg::Q_W-1:0] value_3_i,
  input  logic                         tail_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [wf23_pkg::Q_W-1:0] out_even_o,
  output logic signed [wf23_pkg::Q_W-1:0] out_odd_o,
  output logic                         odd_valid_o,
  output logic [wf23_pkg::CH_W-1:0]    out_channel_o,
  input  logic                         cfg_we_i,
  input  logic [wf23_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [wf23_pkg::Q_W-1:0]     cfg_wdata_i
);

  localparam int QW = wf23_pkg::Q_W;
  localparam int NT = wf23_pkg::TAPS;

  // Clamp bounds.
  logic signed [QW-1:0] clamp_min_q, clamp_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clamp_min_q <= wf23_pkg::Q_MIN;
      clamp_max_q <= wf23_pkg::Q_MAX;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wf23_pkg::CFG_CLAMP_MIN: clamp_min_q <= $signed(cfg_wdata_i);
        wf23_pkg::CFG_CLAMP_MAX: clamp_max_q <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // Pipeline advance and input decode.
  logic adv, in_acc, ch_ok, row_ok;
  logic wr_wt, wr_bias, rd_data;
  logic [wf23_pkg::WT_AW-1:0] wt_addr;
  logic [wf23_pkg::PS_AW-1:0] ch_addr;
  wf23_pkg::row_t in_row;

  logic s5_emit_q, out_valid_q;

  assign adv        = !(out_valid_q && !out_ready_i && s5_emit_q);
  assign in_ready_o = adv;
  assign in_acc     = in_valid_i && adv;

  assign ch_ok   = int'(channel_i) < wf23_pkg::CHANNELS;
  assign row_ok  = int'(row_i) < wf23_pkg::ROWS;
  assign wr_wt   = in_acc && ch_ok && row_ok && (mode_i == wf23_pkg::MODE_WEIGHT);
  assign wr_bias = in_acc && ch_ok && (mode_i == wf23_pkg::MODE_BIAS);
  assign rd_data = in_acc && ch_ok && row_ok && (mode_i == wf23_pkg::MODE_DATA);

  assign wt_addr = wf23_pkg::WT_AW'(int'(channel_i) * wf23_pkg::ROWS + int'(row_i));
  assign ch_addr = wf23_pkg::PS_AW'(channel_i);
  assign in_row  = {value_3_i, value_2_i, value_1_i, value_0_i};

  // Weight and bias memories: written and read at acceptance.
  wf23_pkg::row_t       wt_mem [wf23_pkg::WT_ROWS];
  wf23_pkg::row_t       wt_rd_q;
  logic [QW-1:0]        bias_mem [wf23_pkg::CHANNELS];
  logic [QW-1:0]        bias_rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_wt) begin
      wt_mem[wt_addr] <= in_row;
    end
    if (rd_data) begin
      wt_rd_q <= wt_mem[wt_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_bias) begin
      bias_mem[ch_addr] <= value_0_i;
    end
    if (rd_data) begin
      bias_rd_q <= bias_mem[ch_addr];
    end
  end

  // Stage registers.
  logic                        s1_dv_q, s2_dv_q, s3_dv_q, s3_emit_q, s4_emit_q;
  logic [wf23_pkg::CH_W-1:0]   s1_ch_q, s2_ch_q, s3_ch_q, s4_ch_q, s5_ch_q;
  logic [wf23_pkg::ROW_W-1:0]  s1_row_q, s2_row_q;
  logic                        s1_tail_q, s2_tail_q, s3_tail_q, s4_tail_q, s5_tail_q;
  wf23_pkg::row_t              s1_val_q, s2_m_q, s3_m_q;
  logic signed [2*QW-1:0]      s2_prod_q [NT];
  logic [QW-1:0]               s2_bias_q, s3_bias_q, s4_bias_q, s5_bias_q;
  logic signed [QW-1:0]        s4_e_q, s4_o_q, s5_e_q, s5_o_q;
  logic [QW-1:0]               s4_m2_q, s4_m3_q;

  // Partial sum memory: read at acceptance, written back from stage 2.
  wf23_pkg::row_t ps_mem [wf23_pkg::CHANNELS];
  wf23_pkg::row_t ps_rd_q;
  wf23_pkg::row_t s2_m_new;

  always_ff @(posedge clk_i) begin
    if (adv && s2_dv_q) begin
      ps_mem[wf23_pkg::PS_AW'(s2_ch_q)] <= s2_m_new;
    end
    if (rd_data) begin
      ps_rd_q <= ps_mem[ch_addr];
    end
  end

  // Stage 1: four products, and the partial sums with forwarding from the
  // two older words whose write-back the memory read did not see.
  logic signed [2*QW-1:0] s1_prod [NT];
  wf23_pkg::row_t         s1_m_fwd;

  always_comb begin
    for (int k = 0; k < NT; k++) begin
      s1_prod[k] = $signed(wt_rd_q[k]) * $signed(s1_val_q[k]);
    end
    if (s2_dv_q && (s2_ch_q == s1_ch_q)) begin
      s1_m_fwd = s2_m_new;
    end else if (s3_dv_q && (s3_ch_q == s1_ch_q)) begin
      s1_m_fwd = s3_m_q;
    end else begin
      s1_m_fwd = ps_rd_q;
    end
  end

  // Stage 2: scale products, start or accumulate the sums; the tail keeps m3.
  always_comb begin
    logic signed [QW-1:0] q;
    for (int k = 0; k < NT; k++) begin
      q = wf23_pkg::prod_sat(s2_prod_q[k]);
      if ((k == NT - 1) && s2_tail_q) begin
        s2_m_new[k] = s2_m_q[k];
      end else if (s2_row_q == wf23_pkg::ROW_FIRST) begin
        s2_m_new[k] = q;
      end else begin
        s2_m_new[k] = wf23_pkg::sat_add($signed(s2_m_q[k]), q);
      end
    end
  end

  // Final bias add and clamp into the output register.
  logic signed [QW-1:0] fin_e, fin_o;

  assign fin_e = wf23_pkg::clamp(wf23_pkg::sat_add(s5_e_q, $signed(s5_bias_q)),
                                 clamp_min_q, clamp_max_q);
  assign fin_o = wf23_pkg::clamp(wf23_pkg::sat_add(s5_o_q, $signed(s5_bias_q)),
                                 clamp_min_q, clamp_max_q);

  // Pipeline control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_dv_q     <= 1'b0;
      s2_dv_q     <= 1'b0;
      s3_dv_q     <= 1'b0;
      s3_emit_q   <= 1'b0;
      s4_emit_q   <= 1'b0;
      s5_emit_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        s1_dv_q   <= rd_data;
        s2_dv_q   <= s1_dv_q;
        s3_dv_q   <= s2_dv_q;
        s3_emit_q <= s2_dv_q && (s2_row_q == wf23_pkg::ROW_LAST);
        s4_emit_q <= s3_emit_q;
        s5_emit_q <= s4_emit_q;
      end
      // A new result word takes the output register; otherwise a taken word leaves.
      if (adv && s5_emit_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ch_q   <= channel_i;
      s1_row_q  <= row_i;
      s1_tail_q <= tail_i;
      s1_val_q  <= in_row;

      s2_ch_q   <= s1_ch_q;
      s2_row_q  <= s1_row_q;
      s2_tail_q <= s1_tail_q;
      s2_m_q    <= s1_m_fwd;
      s2_bias_q <= bias_rd_q;
      for (int k = 0; k < NT; k++) begin
        s2_prod_q[k] <= s1_prod[k];
      end

      s3_ch_q   <= s2_ch_q;
      s3_tail_q <= s2_tail_q;
      s3_m_q    <= s2_m_new;
      s3_bias_q <= s2_bias_q;

      s4_ch_q   <= s3_ch_q;
      s4_tail_q <= s3_tail_q;
      s4_e_q    <= wf23_pkg::sat_add($signed(s3_m_q[0]), $signed(s3_m_q[1]));
      s4_o_q    <= wf23_pkg::sat_sub($signed(s3_m_q[1]), $signed(s3_m_q[2]));
      s4_m2_q   <= s3_m_q[2];
      s4_m3_q   <= s3_m_q[3];
      s4_bias_q <= s3_bias_q;

      s5_ch_q   <= s4_ch_q;
      s5_tail_q <= s4_tail_q;
      s5_e_q    <= wf23_pkg::sat_add(s4_e_q, $signed(s4_m2_q));
      s5_o_q    <= wf23_pkg::sat_add(s4_o_q, $signed(s4_m3_q));
      s5_bias_q <= s4_bias_q;

      if (s5_emit_q) begin
        out_even_o    <= fin_e;
        out_odd_o     <= s5_tail_q ? '0 : fin_o;
        odd_valid_o   <= !s5_tail_q;
        out_channel_o <= s5_ch_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[rtl/wf23_checker.sv]
// Port-level checker of the Winograd F(2,3) output block and its bind.
module wf23_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic signed [wf23_pkg::Q_W-1:0] out_even_o,
  input logic signed [wf23_pkg::Q_W-1:0] out_odd_o,
  input logic                         odd_valid_o
);

  // A result word that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its pixels.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_even_o) && $stable(out_odd_o))
    else $error("result word changed while stalled");

  // Tail results carry a zero odd pixel.
  a_tail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !odd_valid_o |-> out_odd_o == '0)
    else $error("odd pixel not zero on a tail result");

  // The input side stalls only behind a result the receiver refuses.
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a blocked result");

endmodule

bind winograd_f23_depthwise_output wf23_checker u_wf23_checker (.*);
